@@ sv/mcspg_pkg.sv @@
package mcspg_pkg;

  // Default channel count and the number of channels the 3-bit channel field can address
  localparam int CHANNELS_DEF = 8;
  localparam int CH_ADDR      = 8;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN          = 3'd4;

  localparam logic [15:0] MIN_PULSE_RST    = 16'd8000;
  localparam logic [15:0] MAX_PULSE_RST    = 16'd16000;
  localparam logic [5:0]  OFFSET_SCALE_RST = 6'd8;
  localparam logic [19:0] FRAME_GAP_RST    = 20'd160000;

  // Input function codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_ATTACH   = 2'd1;
  localparam logic [1:0] FUNC_POSITION = 2'd2;
  localparam logic [1:0] FUNC_TRIM     = 2'd3;

  localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_ATTACH,
    OP_POS,
    OP_TRIM
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [2:0]         ch;
    logic [15:0]        position;
    logic signed [7:0]  trim_low;
    logic signed [7:0]  trim_high;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic busy;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SPAN,
    BK_WRITE
  } bk_state_t;

endpackage

@@ sv/mcspg_if.sv @@
interface mcspg_in_if import mcspg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [2:0]        channel;
  logic [15:0]       position;
  logic signed [7:0] trim_low;
  logic signed [7:0] trim_high;

  modport source (output valid, func, channel, position, trim_low, trim_high, input ready);
  modport sink   (input valid, func, channel, position, trim_low, trim_high, output ready);
endinterface

interface mcspg_out_if import mcspg_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] pins;
  logic       frame_start;

  modport source (output valid, pins, frame_start, input ready);
  modport sink   (input valid, pins, frame_start, output ready);
endinterface

@@ sv/multi_channel_servo_pulse_generator_core.sv @@
// Path: an accepted item passes through the command queue and then the result register.
// Throughput: tick, attach and trim items retire one per cycle when the output is free;
// a position command holds the back end (trim product, span product, saturate, write width).
// Reset: synchronous active-low rst_n restores register defaults, detaches all channels,
// clears widths and trims and drops all pins; no clearing pass, items accepted at once.
module multi_channel_servo_pulse_generator_core import mcspg_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mcspg_in_if.sink              in_ch,
  mcspg_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Front to back: head of the command queue and the pop strobe
  q_head_t  q_head;
  logic     q_pop;
  bk_stat_t bk_stat;

  // Front: accept items and classify them, out-of-range channels drop to no-ops.
  // Its queue keeps taking items while the back end works on a position command
  // or while a finished result waits on the output, as long as it has room.
  mcspg_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back: hold configuration and channel state, advance the frame timer on ticks,
  // and compute trimmed pulse widths with two registered multiply steps.
  mcspg_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .stat      (bk_stat),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // Pop only a queue entry that holds an item
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // No item leaves the queue while a position command is still being computed
  a_pop_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_stat.busy)
    else $error("queue popped while back end busy");

  // After an item is accepted, the queue head holds a valid entry in the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> q_head.valid)
    else $error("accepted item missing from queue");
`endif

endmodule

@@ sv/mcspg_front.sv @@
module mcspg_front import mcspg_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mcspg_in_if.sink     in_ch,
  output q_head_t      q_head,
  input  logic         q_pop
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = QAW + 1;

  item_t          q_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           ch_ok;
  item_t          cls;

  assign in_ch.ready = (cnt_r != QCW'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign ch_ok       = int'(in_ch.channel) < CHANNELS;

  // Classify: out-of-range channel commands become no-ops
  always_comb begin
    cls.ch        = in_ch.channel;
    cls.position  = in_ch.position;
    cls.trim_low  = in_ch.trim_low;
    cls.trim_high = in_ch.trim_high;
    unique case (in_ch.func)
      FUNC_TICK:     cls.op = OP_TICK;
      FUNC_ATTACH:   cls.op = ch_ok ? OP_ATTACH : OP_NOP;
      FUNC_POSITION: cls.op = ch_ok ? OP_POS : OP_NOP;
      FUNC_TRIM:     cls.op = ch_ok ? OP_TRIM : OP_NOP;
      default:       cls.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_r[rd_ptr_r];

endmodule

@@ sv/mcspg_back.sv @@
module mcspg_back import mcspg_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  q_head_t               q_head,
  output logic                  q_pop,
  output bk_stat_t              stat,
  mcspg_out_if.source           out_ch
);

  localparam int NCH = (CHANNELS < CH_ADDR) ? CHANNELS : CH_ADDR;

  bk_state_t state_r, state_nxt;

  // Configuration
  logic [15:0] min_r, min_nxt;
  logic [15:0] max_r, max_nxt;
  logic [5:0]  scale_r, scale_nxt;
  logic [19:0] gap_r, gap_nxt;
  logic        run_r, run_nxt;

  // Channel state
  logic [NCH-1:0]    attached_r, attached_nxt;
  logic [15:0]       pw_r [NCH];
  logic [15:0]       pw_nxt [NCH];
  logic signed [7:0] lt_r [NCH];
  logic signed [7:0] lt_nxt [NCH];
  logic signed [7:0] ht_r [NCH];
  logic signed [7:0] ht_nxt [NCH];

  // Frame timing
  logic [19:0]    tick_r, tick_nxt;
  logic           in_gap_r, in_gap_nxt;
  logic [NCH-1:0] pins_r, pins_nxt;

  // Position datapath
  logic [2:0]         ch_r, ch_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic signed [14:0] plo_r, plo_nxt;
  logic signed [14:0] phi_r, phi_nxt;
  logic signed [17:0] lo_r, lo_nxt;
  logic [32:0]        mul_r, mul_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_pins_r, out_pins_nxt;
  logic       out_fs_r, out_fs_nxt;

  logic               out_free;
  logic               fs;
  item_t              it;
  logic [NCH-1:0]     alive0, alive_cur;
  logic signed [7:0]  lt_sel, ht_sel;
  logic [16:0]        mid_sum;
  logic signed [17:0] lo_c, hi_c, span_c;
  logic [16:0]        span_u;
  logic signed [18:0] w_c;
  logic [15:0]        w_sat;

  assign it       = q_head.item;
  assign out_free = !out_valid_r || out_ch.ready;
  assign mid_sum  = {1'b0, min_r} + {1'b0, max_r};

  always_comb begin
    lt_sel = '0;
    ht_sel = '0;
    for (int i = 0; i < NCH; i++) begin
      alive0[i]    = (pw_r[i] != '0);
      alive_cur[i] = ({4'b0, pw_r[i]} > tick_r);
      if (it.ch == 3'(i)) begin
        lt_sel = lt_r[i];
        ht_sel = ht_r[i];
      end
    end
  end

  always_comb begin
    lo_c   = $signed({2'b00, min_r}) + 18'(plo_r);
    hi_c   = $signed({2'b00, max_r}) + 18'(phi_r);
    span_c = hi_c - lo_c;
    span_u = span_c[17] ? 17'd0 : span_c[16:0];
    w_c    = 19'(lo_r) + $signed({2'b00, mul_r[32:16]});
    if (w_c < 0) begin
      w_sat = '0;
    end else if (w_c > $signed({3'b000, WIDTH_MAX})) begin
      w_sat = WIDTH_MAX;
    end else begin
      w_sat = w_c[15:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    scale_nxt    = scale_r;
    gap_nxt      = gap_r;
    run_nxt      = run_r;
    attached_nxt = attached_r;
    pw_nxt       = pw_r;
    lt_nxt       = lt_r;
    ht_nxt       = ht_r;
    tick_nxt     = tick_r;
    in_gap_nxt   = in_gap_r;
    pins_nxt     = pins_r;
    ch_nxt       = ch_r;
    pos_nxt      = pos_r;
    plo_nxt      = plo_r;
    phi_nxt      = phi_r;
    lo_nxt       = lo_r;
    mul_nxt      = mul_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pins_nxt  = out_pins_r;
    out_fs_nxt    = out_fs_r;
    q_pop         = 1'b0;
    fs            = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          unique case (it.op)
            OP_TICK: begin
              if (!run_r) begin
                pins_nxt   = '0;
                in_gap_nxt = 1'b1;
                tick_nxt   = '0;
              end else if (in_gap_r) begin
                if (tick_r == '0) begin
                  pins_nxt   = attached_r & alive0;
                  fs         = 1'b1;
                  in_gap_nxt = 1'b0;
                  tick_nxt   = 20'd1;
                  if (pins_nxt == '0) begin
                    in_gap_nxt = 1'b1;
                    tick_nxt   = gap_r;
                  end
                end else begin
                  tick_nxt = tick_r - 20'd1;
                end
              end else begin
                pins_nxt = pins_r & alive_cur;
                tick_nxt = tick_r + 20'd1;
                if (pins_nxt == '0) begin
                  in_gap_nxt = 1'b1;
                  tick_nxt   = gap_r;
                end
              end
            end
            OP_ATTACH: begin
              for (int i = 0; i < NCH; i++) begin
                if (it.ch == 3'(i)) begin
                  attached_nxt[i] = 1'b1;
                  pw_nxt[i]       = mid_sum[16:1];
                end
              end
            end
            OP_POS: begin
              ch_nxt    = it.ch;
              pos_nxt   = it.position;
              plo_nxt   = lt_sel * $signed({1'b0, scale_r});
              phi_nxt   = ht_sel * $signed({1'b0, scale_r});
              state_nxt = BK_SPAN;
            end
            OP_TRIM: begin
              for (int i = 0; i < NCH; i++) begin
                if (it.ch == 3'(i)) begin
                  lt_nxt[i] = it.trim_low;
                  ht_nxt[i] = it.trim_high;
                end
              end
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          out_pins_nxt  = 8'(pins_nxt);
          out_fs_nxt    = fs;
        end
      end
      BK_SPAN: begin
        lo_nxt    = lo_c;
        mul_nxt   = pos_r * span_u;
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        for (int i = 0; i < NCH; i++) begin
          if (ch_r == 3'(i)) begin
            pw_nxt[i] = w_sat;
          end
        end
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PULSE:    min_nxt   = cfg_wdata[15:0];
        CFG_MAX_PULSE:    max_nxt   = cfg_wdata[15:0];
        CFG_OFFSET_SCALE: scale_nxt = cfg_wdata[5:0];
        CFG_FRAME_GAP:    gap_nxt   = cfg_wdata[19:0];
        CFG_RUN: begin
          run_nxt = cfg_wdata[0];
          if (!cfg_wdata[0]) begin
            pins_nxt   = '0;
            in_gap_nxt = 1'b1;
            tick_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MIN_PULSE_RST;
      max_r       <= MAX_PULSE_RST;
      scale_r     <= OFFSET_SCALE_RST;
      gap_r       <= FRAME_GAP_RST;
      run_r       <= 1'b0;
      attached_r  <= '0;
      tick_r      <= '0;
      in_gap_r    <= 1'b1;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        pw_r[i] <= '0;
        lt_r[i] <= '0;
        ht_r[i] <= '0;
      end
    end else begin
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      scale_r     <= scale_nxt;
      gap_r       <= gap_nxt;
      run_r       <= run_nxt;
      attached_r  <= attached_nxt;
      tick_r      <= tick_nxt;
      in_gap_r    <= in_gap_nxt;
      pins_r      <= pins_nxt;
      out_valid_r <= out_valid_nxt;
      pw_r        <= pw_nxt;
      lt_r        <= lt_nxt;
      ht_r        <= ht_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    pos_r      <= pos_nxt;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    lo_r       <= lo_nxt;
    mul_r      <= mul_nxt;
    out_pins_r <= out_pins_nxt;
    out_fs_r   <= out_fs_nxt;
  end

  assign stat.busy          = (state_r != BK_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pins        = out_pins_r;
  assign out_ch.frame_start = out_fs_r;

endmodule
